// ----- rtl/core/mppt_pkg.sv -----
package mppt_pkg;

  localparam int NUM_PINS_DEF  = 16;
  localparam int TIME_BITS_DEF = 32;

  localparam int FIELD_PINS = 16;
  localparam int LEN_W      = 32;
  localparam int PIN_IDX_W  = 6;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_INPUT_MASK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MASK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPORT_MASK = 2'd2;

  localparam logic REQ_PULSE = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef struct packed {
    logic                  req_type;
    logic [PIN_IDX_W-1:0]  pin_index;
    logic [LEN_W-1:0]      pulse_length;
    logic [FIELD_PINS-1:0] pin_levels;
  } req_item_t;

  typedef struct packed {
    logic                  result_kind;
    logic [PIN_IDX_W-1:0]  report_pin;
    logic [LEN_W-1:0]      measured_length;
    logic [FIELD_PINS-1:0] drive_levels;
    logic                  last_result;
  } rsp_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [FIELD_PINS-1:0] data;
  } cfg_item_t;

endpackage

// ----- rtl/core/mppt_if.sv -----
interface mppt_req_if import mppt_pkg::*;;
  logic      valid;
  logic      ready;
  req_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mppt_rsp_if import mppt_pkg::*;;
  logic      valid;
  logic      ready;
  rsp_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mppt_cfg_if import mppt_pkg::*;;
  logic      valid;
  logic      ready;
  cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/mppt_ram.sv -----
module mppt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/multi_pin_pulse_timer_capture.sv -----
// Channel | Dir  | Transaction
// --------+------+-----------------------------------------------------------
// req     | in   | pulse command or one millisecond tick
// rsp     | out  | measured pulse reports, then one drive status (last_result)
// cfg     | in   | register write: input, output and report pin masks
//
// A pulse command goes straight to the drive status. A tick visits each active output
// pin (start/length read, subtract and compare), then each input pin starting a pulse
// (start write) or ending one (start read, subtract, optional report), then drive status.
// The single time subtractor and the start/length RAM read port take one pin at a time.
// Reset (rst, synchronous) clears time, activity, drive bits and masks.
// A full rsp register stalls the sequencer; req waits until the last result is loaded.
module multi_pin_pulse_timer_capture import mppt_pkg::*; #(
  parameter int NUM_PINS  = NUM_PINS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  mppt_req_if.sink   req,
  mppt_rsp_if.source rsp,
  mppt_cfg_if.sink   cfg
);

  localparam int NP = (NUM_PINS < FIELD_PINS) ? NUM_PINS : FIELD_PINS;
  localparam int AW = (NP > 1) ? $clog2(NP) : 1;
  localparam int CW = (TIME_BITS > LEN_W) ? TIME_BITS : LEN_W;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_P1_PICK = 3'd1;
  localparam logic [2:0] S_P1_EVAL = 3'd2;
  localparam logic [2:0] S_P2_PICK = 3'd3;
  localparam logic [2:0] S_P2_EVAL = 3'd4;
  localparam logic [2:0] S_FINAL   = 3'd5;

  logic [2:0]           state, state_next;
  logic [NP-1:0]        in_mask, out_mask, rep_mask;
  logic [NP-1:0]        active, active_next;
  logic [NP-1:0]        drive, drive_next;
  logic [NP-1:0]        pending, pending_next;
  logic [NP-1:0]        levels;
  logic [TIME_BITS-1:0] time_now;
  logic [AW-1:0]        cur_pin;

  logic [NP-1:0]        cfg_val, new_in, new_out, changed;
  logic                 req_fire, cfg_fire, slot_free;
  logic [AW-1:0]        low_pin;
  logic [NP-1:0]        low_bit;
  logic                 cmd_hit;

  logic                 st_we, st_re, tg_we;
  logic [AW-1:0]        st_waddr, rd_addr;
  logic [TIME_BITS-1:0] st_wdata, st_rdata;
  logic [LEN_W-1:0]     tg_rdata;
  logic [TIME_BITS-1:0] elapsed;

  logic                 load_rsp;
  rsp_item_t            rsp_load;
  logic [FIELD_PINS-1:0] drive16;

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign req_fire  = req.valid && req.ready;
  assign cfg_fire  = cfg.valid && cfg.ready;
  assign slot_free = !rsp.valid || rsp.ready;
  assign elapsed   = time_now - st_rdata;

  mppt_ram #(.WIDTH(TIME_BITS), .DEPTH(NP)) u_start_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (rd_addr),
    .rdata (st_rdata)
  );

  mppt_ram #(.WIDTH(LEN_W), .DEPTH(NP)) u_length_ram (
    .clk   (clk),
    .we    (tg_we),
    .waddr (req.data.pin_index[AW-1:0]),
    .wdata (req.data.pulse_length),
    .re    (st_re),
    .raddr (rd_addr),
    .rdata (tg_rdata)
  );

  // lowest pending pin
  always_comb begin
    low_pin = '0;
    low_bit = '0;
    for (int i = NP - 1; i >= 0; i--) begin
      if (pending[i]) begin
        low_pin = AW'(i);
        low_bit = '0;
        low_bit[i] = 1'b1;
      end
    end
  end

  always_comb begin
    cfg_val = cfg.data.data[NP-1:0];
    new_in  = in_mask;
    new_out = out_mask;
    if (cfg.data.index == REG_INPUT_MASK) begin
      new_in = cfg_val;
    end
    if (cfg.data.index == REG_OUTPUT_MASK) begin
      new_out = cfg_val;
    end
    changed = (out_mask ^ new_out) | ((in_mask & ~out_mask) ^ (new_in & ~new_out));
  end

  assign cmd_hit = (req.data.pin_index < PIN_IDX_W'(NP)) &&
                   out_mask[req.data.pin_index[AW-1:0]];

  always_comb begin
    drive16 = '0;
    drive16[NP-1:0] = drive_next;
  end

  always_comb begin
    state_next   = state;
    active_next  = active;
    drive_next   = drive;
    pending_next = pending;
    st_we        = 1'b0;
    st_waddr     = req.data.pin_index[AW-1:0];
    st_wdata     = time_now;
    tg_we        = 1'b0;
    st_re        = 1'b0;
    rd_addr      = low_pin;
    load_rsp     = 1'b0;
    rsp_load     = '0;

    unique case (state)
      S_IDLE: begin
        if (req_fire) begin
          if (req.data.req_type == REQ_PULSE) begin
            if (cmd_hit) begin
              if (req.data.pulse_length != '0) begin
                st_we = 1'b1;
                tg_we = 1'b1;
                active_next[req.data.pin_index[AW-1:0]] = 1'b1;
                drive_next[req.data.pin_index[AW-1:0]]  = 1'b1;
              end else begin
                active_next[req.data.pin_index[AW-1:0]] = 1'b0;
                drive_next[req.data.pin_index[AW-1:0]]  = 1'b0;
              end
            end
            state_next = S_FINAL;
          end else begin
            pending_next = out_mask & active;
            state_next   = S_P1_PICK;
          end
        end
      end
      S_P1_PICK: begin
        if (pending == '0) begin
          // inputs that rise while idle or fall while timing
          pending_next = in_mask & ~out_mask & (levels ^ active);
          state_next   = S_P2_PICK;
        end else begin
          st_re        = 1'b1;
          pending_next = pending & ~low_bit;
          state_next   = S_P1_EVAL;
        end
      end
      S_P1_EVAL: begin
        if (CW'(elapsed) >= CW'(tg_rdata)) begin
          active_next[cur_pin] = 1'b0;
          drive_next[cur_pin]  = 1'b0;
        end
        state_next = S_P1_PICK;
      end
      S_P2_PICK: begin
        if (pending == '0) begin
          state_next = S_FINAL;
        end else begin
          pending_next = pending & ~low_bit;
          if (levels[low_pin]) begin
            st_we    = 1'b1;
            st_waddr = low_pin;
            active_next[low_pin] = 1'b1;
          end else begin
            st_re      = 1'b1;
            state_next = S_P2_EVAL;
          end
        end
      end
      S_P2_EVAL: begin
        if (!rep_mask[cur_pin]) begin
          active_next[cur_pin] = 1'b0;
          state_next = S_P2_PICK;
        end else if (slot_free) begin
          active_next[cur_pin] = 1'b0;
          load_rsp = 1'b1;
          rsp_load.result_kind     = KIND_REPORT;
          rsp_load.report_pin      = PIN_IDX_W'(cur_pin);
          rsp_load.measured_length = LEN_W'(elapsed);
          rsp_load.drive_levels    = drive16;
          rsp_load.last_result     = 1'b0;
          state_next = S_P2_PICK;
        end
      end
      S_FINAL: begin
        if (slot_free) begin
          load_rsp = 1'b1;
          rsp_load.result_kind  = KIND_STATUS;
          rsp_load.drive_levels = drive16;
          rsp_load.last_result  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // drop activity of pins whose role changes
    if (cfg_fire) begin
      active_next = active_next & ~changed;
      drive_next  = drive_next & ~changed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      active    <= '0;
      drive     <= '0;
      pending   <= '0;
      time_now  <= '0;
      in_mask   <= '0;
      out_mask  <= '0;
      rep_mask  <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state   <= state_next;
      active  <= active_next;
      drive   <= drive_next;
      pending <= pending_next;
      if (req_fire && req.data.req_type == REQ_TICK) begin
        time_now <= time_now + TIME_BITS'(1);
      end
      if (cfg_fire) begin
        in_mask  <= new_in;
        out_mask <= new_out;
        if (cfg.data.index == REG_REPORT_MASK) begin
          rep_mask <= cfg_val;
        end
      end
      if (load_rsp) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      levels <= req.data.pin_levels[NP-1:0];
    end
    if (st_re) begin
      cur_pin <= low_pin;
    end
    if (load_rsp) begin
      rsp.data <= rsp_load;
    end
  end

endmodule

// ----- rtl/core/mppt_checker.sv -----
module mppt_checker import mppt_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      req_valid,
  input logic      req_ready,
  input logic      req_type,
  input logic      rsp_valid,
  input logic      rsp_ready,
  input rsp_item_t rsp_data
);

  // a drive status carries no pin and no width
  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.result_kind == KIND_STATUS |->
      rsp_data.report_pin == '0 && rsp_data.measured_length == '0)
    else $error("drive status with report fields set");

  a_report_not_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.result_kind == KIND_REPORT |-> !rsp_data.last_result)
    else $error("report flagged as last result");

  a_busy_mid_item: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_ready && !rsp_data.last_result |-> !req_ready)
    else $error("new transaction taken before last result");

  a_pulse_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_type == REQ_PULSE |=> !req_ready)
    else $error("pulse command did not hold off input");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("stalled result changed");

endmodule

bind multi_pin_pulse_timer_capture mppt_checker u_mppt_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .req_type  (req.data.req_type),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);

// ----- tb/multi_pin_pulse_timer_capture_test.sv -----
`timescale 1ns / 1ps

module multi_pin_pulse_timer_capture_test;
  import mppt_pkg::*;

  localparam int NP = NUM_PINS_DEF;
  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE_CYCLES = 120;
  localparam int HOLD_AT = 75;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_PHASES = 5;
  localparam int ITEMS_PER_PHASE = 36;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic clk;
  logic rst;

  mppt_req_if req_ch ();
  mppt_rsp_if rsp_ch ();
  mppt_cfg_if cfg_ch ();

  multi_pin_pulse_timer_capture u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // Mirror of the block state
  logic [NP-1:0] in_mask;
  logic [NP-1:0] out_mask;
  logic [NP-1:0] rep_mask;
  logic [31:0]   ms_now;
  logic [NP-1:0] busy_pins;
  logic [NP-1:0] drive_pins;
  logic [31:0]   start_ms [NP];
  logic [31:0]   length_ms [NP];

  req_item_t     pending_items [$];
  rsp_item_t     due_results [$];
  logic [15:0]   pin_level_state;

  int  items_accepted;
  int  results_checked;
  int  reports_checked;
  int  mismatches;
  int  cycle_count;
  int  hold_left;
  bit  hold_used;
  bit  no_idle;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_pin_timers();
    in_mask = '0;
    out_mask = '0;
    rep_mask = '0;
    ms_now = '0;
    busy_pins = '0;
    drive_pins = '0;
    for (int p = 0; p < NP; p++) begin
      start_ms[p] = '0;
      length_ms[p] = '0;
    end
  endfunction

  function automatic void apply_mask_write(input cfg_item_t w);
    logic [NP-1:0] old_out;
    logic [NP-1:0] old_in;
    logic [NP-1:0] changed;
    old_out = out_mask;
    old_in = in_mask & ~out_mask;
    case (w.index)
      REG_INPUT_MASK: in_mask = w.data[NP-1:0];
      REG_OUTPUT_MASK: out_mask = w.data[NP-1:0];
      REG_REPORT_MASK: rep_mask = w.data[NP-1:0];
      default: ;
    endcase
    // drop activity on every pin whose role moved
    changed = (old_out ^ out_mask) | (old_in ^ (in_mask & ~out_mask));
    busy_pins &= ~changed;
    drive_pins &= ~changed;
  endfunction

  function automatic void push_drive_status();
    rsp_item_t r;
    r = '0;
    r.result_kind = KIND_STATUS;
    r.drive_levels = drive_pins;
    r.last_result = 1'b1;
    due_results.push_back(r);
  endfunction

  function automatic void step_pin_timers(input req_item_t it);
    int            pin;
    logic [31:0]   elapsed;
    logic [NP-1:0] ins;
    rsp_item_t     r;
    pin = int'(it.pin_index);
    if (it.req_type == REQ_PULSE) begin
      if (pin < NP) begin
        if (out_mask[pin]) begin
          if (it.pulse_length != '0) begin
            start_ms[pin] = ms_now;
            length_ms[pin] = it.pulse_length;
            busy_pins[pin] = 1'b1;
            drive_pins[pin] = 1'b1;
          end else if (busy_pins[pin]) begin
            busy_pins[pin] = 1'b0;
            drive_pins[pin] = 1'b0;
          end
        end
      end
    end else begin
      ms_now = ms_now + 32'd1;
      for (int p = 0; p < NP; p++) begin
        elapsed = ms_now - start_ms[p];
        if (out_mask[p] && busy_pins[p] && elapsed >= length_ms[p]) begin
          busy_pins[p] = 1'b0;
          drive_pins[p] = 1'b0;
        end
      end
      ins = in_mask & ~out_mask;
      for (int p = 0; p < NP; p++) begin
        if (ins[p]) begin
          if (it.pin_levels[p]) begin
            if (!busy_pins[p]) begin
              busy_pins[p] = 1'b1;
              start_ms[p] = ms_now;
            end
          end else if (busy_pins[p]) begin
            elapsed = ms_now - start_ms[p];
            busy_pins[p] = 1'b0;
            if (rep_mask[p]) begin
              r = '0;
              r.result_kind = KIND_REPORT;
              r.report_pin = p[PIN_IDX_W-1:0];
              r.measured_length = elapsed;
              r.drive_levels = drive_pins;
              r.last_result = 1'b0;
              due_results.push_back(r);
            end
          end
        end
      end
    end
    push_drive_status();
  endfunction

  // Driver: hold an offered transaction until it is taken
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        step_pin_timers(req_ch.data);
        items_accepted <= items_accepted + 1;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_items.size() != 0 && (no_idle || $urandom_range(99) >= 30)) begin
          req_ch.valid <= 1'b1;
          req_ch.data <= pending_items.pop_front();
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, so the result register fills and req stalls
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_used && items_accepted >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end
  end

  // Monitor
  always @(posedge clk) begin
    rsp_item_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (due_results.size() == 0) begin
          $error("result with none expected: kind %0d pin %0d length %0d",
                 rsp_ch.data.result_kind, rsp_ch.data.report_pin,
                 rsp_ch.data.measured_length);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          results_checked++;
          if (rsp_ch.data.result_kind == KIND_REPORT) reports_checked++;
          if (rsp_ch.data.result_kind !== want.result_kind) begin
            $error("result_kind: expected %0d, got %0d",
                   want.result_kind, rsp_ch.data.result_kind);
            mismatches++;
          end
          if (rsp_ch.data.report_pin !== want.report_pin) begin
            $error("report_pin: expected %0d, got %0d",
                   want.report_pin, rsp_ch.data.report_pin);
            mismatches++;
          end
          if (rsp_ch.data.measured_length !== want.measured_length) begin
            $error("measured_length: expected %0d, got %0d",
                   want.measured_length, rsp_ch.data.measured_length);
            mismatches++;
          end
          if (rsp_ch.data.drive_levels !== want.drive_levels) begin
            $error("drive_levels: expected %h, got %h",
                   want.drive_levels, rsp_ch.data.drive_levels);
            mismatches++;
          end
          if (rsp_ch.data.last_result !== want.last_result) begin
            $error("last_result: expected %0d, got %0d",
                   want.last_result, rsp_ch.data.last_result);
            mismatches++;
          end
        end
      end
      rsp_ch.ready <= (hold_left == 0) && (no_idle || $urandom_range(99) >= 30);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d results still due",
             cycle_count, due_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Call right after a rising edge; returns right after one
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_item_t w;
    w.index = idx;
    w.data = val;
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= w;
    do @(posedge clk); while (!cfg_ch.ready);
    apply_mask_write(cfg_ch.data);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic void push_item(input logic kind, input int pin,
                                    input logic [31:0] len, input logic [15:0] lv);
    req_item_t it;
    it.req_type = kind;
    it.pin_index = pin[PIN_IDX_W-1:0];
    it.pulse_length = len;
    it.pin_levels = lv;
    pending_items.push_back(it);
  endfunction

  function automatic void push_tick(input logic [15:0] lv);
    push_item(REQ_TICK, $urandom_range(63), $urandom, lv);
  endfunction

  function automatic void push_pulse(input int pin, input logic [31:0] len);
    push_item(REQ_PULSE, pin, len, 16'($urandom));
  endfunction

  // Mostly slowly drifting input levels so pulses last several ticks
  function automatic void queue_random(input int count);
    int          roll;
    int          pin;
    logic [31:0] len;
    logic [15:0] flips;
    for (int k = 0; k < count; k++) begin
      roll = $urandom_range(99);
      if (roll < 60) begin
        if ($urandom_range(9) == 0) begin
          pin_level_state = 16'($urandom);
        end else begin
          for (int b = 0; b < 16; b++) flips[b] = ($urandom_range(5) == 0);
          pin_level_state ^= flips;
        end
        push_tick(pin_level_state);
      end else begin
        pin = (roll < 95) ? $urandom_range(NP - 1) : $urandom_range(63);
        case ($urandom_range(9))
          0: len = '0;
          1: len = $urandom;
          2: len = 32'hFFFF_FFFF;
          default: len = $urandom_range(8, 1);
        endcase
        push_pulse(pin, len);
      end
    end
  endfunction

  // Wait until every transaction is taken and answered, then let the block settle
  task automatic drain_and_settle();
    do @(negedge clk);
    while (pending_items.size() != 0 || req_ch.valid || due_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    items_accepted = 0;
    results_checked = 0;
    reports_checked = 0;
    mismatches = 0;
    cycle_count = 0;
    no_idle = 1'b0;
    pin_level_state = '0;
    clear_pin_timers();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // No roles yet: commands and levels are ignored
    write_reg(REG_UNUSED, 16'hFFFF);
    @(negedge clk);
    push_pulse(0, 32'd5);
    push_tick(16'hFFFF);
    drain_and_settle();

    write_reg(REG_INPUT_MASK, 16'hFFFF);
    write_reg(REG_OUTPUT_MASK, 16'h00FF);
    write_reg(REG_REPORT_MASK, 16'hF0F0);
    @(negedge clk);
    push_pulse(0, 32'd1);
    push_pulse(7, 32'hFFFF_FFFF);
    push_pulse(3, 32'd3);
    push_pulse(63, 32'd5);
    push_pulse(16, 32'd5);
    push_pulse(9, 32'd5);
    push_pulse(5, 32'd0);
    push_tick(16'hFFFF);
    push_pulse(3, 32'd2);
    push_tick(16'hFFFF);
    push_tick(16'h0000);
    push_pulse(7, 32'd0);
    push_tick(16'hAAAA);
    push_tick(16'h5555);
    push_tick(16'h0000);
    drain_and_settle();

    // Every pin an input and reported: one tick ends all sixteen
    write_reg(REG_OUTPUT_MASK, 16'h0000);
    write_reg(REG_REPORT_MASK, 16'hFFFF);
    @(negedge clk);
    push_tick(16'hFFFF);
    push_tick(16'hFFFF);
    push_tick(16'h0000);
    push_tick(16'hFFFF);
    drain_and_settle();

    // Role change while inputs are timing
    write_reg(REG_OUTPUT_MASK, 16'h000F);
    @(negedge clk);
    push_tick(16'h0000);
    push_pulse(2, 32'd2);
    push_tick(16'h0000);
    push_tick(16'h0000);
    push_tick(16'h0000);
    drain_and_settle();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_INPUT_MASK, 16'hFFFF);
          write_reg(REG_OUTPUT_MASK, 16'h00FF);
          write_reg(REG_REPORT_MASK, 16'hFFFF);
        end
        1: begin
          write_reg(REG_REPORT_MASK, 16'($urandom));
          write_reg(REG_OUTPUT_MASK, 16'($urandom));
          write_reg(REG_INPUT_MASK, 16'($urandom));
        end
        2: begin
          write_reg(REG_OUTPUT_MASK, 16'h0000);
          write_reg(REG_INPUT_MASK, 16'hFFFF);
          write_reg(REG_REPORT_MASK, 16'($urandom));
          no_idle <= 1'b1;
        end
        3: begin
          write_reg(REG_INPUT_MASK, 16'($urandom));
          write_reg(REG_OUTPUT_MASK, 16'hFFFF);
          write_reg(REG_REPORT_MASK, 16'h0000);
        end
        default: begin
          write_reg(REG_OUTPUT_MASK, 16'($urandom & $urandom));
          write_reg(REG_INPUT_MASK, 16'($urandom));
          write_reg(REG_REPORT_MASK, 16'hFFFF);
        end
      endcase
      @(negedge clk);
      queue_random(ITEMS_PER_PHASE);
      drain_and_settle();
      no_idle <= 1'b0;
    end

    if (due_results.size() != 0) begin
      $error("%0d expected results never arrived", due_results.size());
      mismatches++;
    end
    $display("Run covered %0d commands and ticks over %0d cycles,", items_accepted,
             cycle_count);
    $display("checking %0d results, %0d of them measured widths.", results_checked,
             reports_checked);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
